// ===== sv/rs2d_pkg.sv =====
// Shared types, widths and codes for the 2D range-sum (summed-area table) unit.
// No dependencies; every other file in this block imports it.
package rs2d_pkg;

   // Matrix limits and field widths
   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int ELEM_WIDTH = 16;
   localparam int SUM_W      = 24;
   localparam int POS_W      = 4;                          // corner index fields
   localparam int CNT_W      = 5;                          // row/col counts, table indices
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int TBL_DEPTH  = MAX_ROWS * MAX_COLS;        // interior entries only
   localparam int TBL_AW     = ROW_W + COL_W;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CNT_W;

   // Sequencer
   localparam int STEP_W      = 3;
   localparam int LOAD_TERMS  = 3;
   localparam int QUERY_TERMS = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DONE
   } state_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT = 1'b0,
      CSR_COL_COUNT = 1'b1
   } csr_index_type;

   // Table port control, sequencer to table
   typedef struct packed {
      logic             rd_en;
      logic [CNT_W-1:0] rd_row;
      logic [CNT_W-1:0] rd_col;
      logic             wr_en;
      logic [CNT_W-1:0] wr_row;
      logic [CNT_W-1:0] wr_col;
      logic [SUM_W-1:0] wr_data;
   } tbl_ctl_type;

endpackage

// ===== sv/rs2d_channels.sv =====
// Valid/ready channel interfaces for the 2D range-sum unit: request and response.
// Depends on rs2d_pkg for field widths.
interface rs2d_req_if;
   import rs2d_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [ELEM_WIDTH-1:0] element;
   logic [POS_W-1:0]             top_row;
   logic [POS_W-1:0]             left_col;
   logic [POS_W-1:0]             bottom_row;
   logic [POS_W-1:0]             right_col;

   modport source (output valid, mode, element, top_row, left_col, bottom_row, right_col,
                   input ready);
   modport sink   (input valid, mode, element, top_row, left_col, bottom_row, right_col,
                   output ready);
endinterface

interface rs2d_rsp_if;
   import rs2d_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] range_sum;
   logic                    query_error;

   modport source (output valid, range_sum, query_error, input ready);
   modport sink   (input valid, range_sum, query_error, output ready);
endinterface

// ===== sv/rs2d_table.sv =====
// Summed-area table store: single write port, one registered read port.
// Border row and column read as zero and are never stored. Depends on rs2d_pkg.
module rs2d_table (
   input  logic                       clock,
   input  rs2d_pkg::tbl_ctl_type      ctl,
   output logic [rs2d_pkg::SUM_W-1:0] rd_data
);
   import rs2d_pkg::*;

   logic [SUM_W-1:0]  mem [TBL_DEPTH];
   logic [SUM_W-1:0]  rd_q_ff;
   logic              border_ff;
   logic [CNT_W-1:0]  rd_row_m1;
   logic [CNT_W-1:0]  rd_col_m1;
   logic [CNT_W-1:0]  wr_row_m1;
   logic [CNT_W-1:0]  wr_col_m1;
   logic [TBL_AW-1:0] rd_addr;
   logic [TBL_AW-1:0] wr_addr;
   logic              rd_border;

   // Interior entry (r, c) with r, c >= 1 lives at {r-1, c-1}
   always_comb begin
      rd_row_m1 = ctl.rd_row - CNT_W'(1);
      rd_col_m1 = ctl.rd_col - CNT_W'(1);
      wr_row_m1 = ctl.wr_row - CNT_W'(1);
      wr_col_m1 = ctl.wr_col - CNT_W'(1);
      rd_addr   = {rd_row_m1[ROW_W-1:0], rd_col_m1[COL_W-1:0]};
      wr_addr   = {wr_row_m1[ROW_W-1:0], wr_col_m1[COL_W-1:0]};
      rd_border = (ctl.rd_row == '0) || (ctl.rd_col == '0);
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff   <= mem[rd_addr];
         border_ff <= rd_border;
      end
   end

   assign rd_data = border_ff ? '0 : rd_q_ff;

endmodule

// ===== sv/range_sum_2d_prefix_table_unit.sv =====
// Top level of the 2D range-sum unit: sequencer, shared accumulator, result register.
// Depends on rs2d_pkg, rs2d_channels (rs2d_req_if, rs2d_rsp_if) and rs2d_table.
//
// Usage
//   Configure row_count (index 0) and col_count (index 1) through the csr_ port while
//   the unit is idle; any count write restarts matrix loading. Counts clamp to 1..16.
//   Request beats with mode = load carry one matrix element each, in row-major order;
//   each load writes one summed-area table entry and returns no response beat. After
//   row_count * col_count loads the matrix is complete; the next load starts a new one.
//   Request beats with mode = query name an inclusive rectangle and return exactly one
//   response beat: the rectangle sum, or query_error with a zero sum for an inverted or
//   out-of-range rectangle or an incomplete matrix.
// Timing
//   One table read per cycle through the single table port, summed by one shared
//   adder. A load reads its terms and then writes its entry; a query reads its terms,
//   or none when it fails its bounds check, and then loads the response register once
//   it is free. A new request is taken only after the current item is finished.
// Reset and stalls
//   Synchronous reset sets both counts to 16, clears the load position and the
//   complete flag, and empties the response register; no table clearing pass is
//   needed. A stalled response holds its beat; a new request is still taken while it
//   waits, and only a finished query waits for the register to drain.
module range_sum_2d_prefix_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rs2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rs2d_pkg::CSR_DATA_W-1:0] csr_wr_data,
   rs2d_req_if.sink                        req_ch,
   rs2d_rsp_if.source                      rsp_ch
);
   import rs2d_pkg::*;

   // Control state
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [CNT_W-1:0]  col_count_ff, col_count_in;
   logic [ROW_W-1:0]  load_row_ff, load_row_in;
   logic [COL_W-1:0]  load_col_ff, load_col_in;
   logic              complete_ff, complete_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item payload
   mode_type          mode_ff;
   logic [CNT_W-1:0]  row_lo_ff, row_hi_ff;
   logic [CNT_W-1:0]  col_lo_ff, col_hi_ff;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              sub_ff;
   logic              err_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic              rsp_err_ff;

   // Combinational
   logic              req_fire;
   logic              req_is_query;
   logic              query_bad;
   logic              restart;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [CNT_W-1:0]  next_col;
   logic [CNT_W-1:0]  next_row;
   logic [STEP_W-1:0] term_count;
   logic              issue;
   logic              sel_row_hi;
   logic              sel_col_hi;
   logic              sel_sub;
   logic              rsp_slot_free;
   logic              rsp_load;
   logic [SUM_W-1:0]  rd_data;
   logic [SUM_W-1:0]  term;
   tbl_ctl_type       tbl_ctl;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxv);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign req_is_query  = (mode_type'(req_ch.mode) == MODE_QUERY);
   assign rsp_slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Query bounds and completeness
   assign query_bad = !complete_ff
                   || (req_ch.top_row > req_ch.bottom_row)
                   || (req_ch.left_col > req_ch.right_col)
                   || ({1'b0, req_ch.bottom_row} >= row_count_ff)
                   || ({1'b0, req_ch.right_col} >= col_count_ff);

   // Load position: restart after a complete matrix or a stale position
   always_comb begin
      restart  = complete_ff
              || ({1'b0, load_row_ff} >= row_count_ff)
              || ({1'b0, load_col_ff} >= col_count_ff);
      cur_row  = restart ? '0 : load_row_ff;
      cur_col  = restart ? '0 : load_col_ff;
      next_col = {1'b0, cur_col} + CNT_W'(1);
      next_row = {1'b0, cur_row} + CNT_W'(1);
   end

   // Configuration and load position
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      load_row_in  = load_row_ff;
      load_col_in  = load_col_ff;
      complete_in  = complete_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_COUNT: row_count_in = clamp_count(csr_wr_data, CNT_W'(MAX_ROWS));
            CSR_COL_COUNT: col_count_in = clamp_count(csr_wr_data, CNT_W'(MAX_COLS));
            default:       row_count_in = row_count_ff;
         endcase
         load_row_in = '0;
         load_col_in = '0;
         complete_in = 1'b0;
      end else if (req_fire && !req_is_query) begin
         complete_in = 1'b0;
         if (next_col >= col_count_ff) begin
            load_col_in = '0;
            if (next_row >= row_count_ff) begin
               load_row_in = '0;
               complete_in = 1'b1;
            end else begin
               load_row_in = next_row[ROW_W-1:0];
            end
         end else begin
            load_row_in = cur_row;
            load_col_in = next_col[COL_W-1:0];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               step_in  = '0;
               state_in = (req_is_query && query_bad) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            if (step_ff == term_count) begin
               step_in  = '0;
               state_in = (mode_ff == MODE_QUERY) ? ST_DONE : ST_IDLE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: term selection, table port, shared accumulator
   always_comb begin
      term_count = (mode_ff == MODE_QUERY) ? STEP_W'(QUERY_TERMS) : STEP_W'(LOAD_TERMS);
      issue      = (state_ff == ST_READ) && (step_ff < term_count);

      // Load:  +P[r][c+1]  +P[r+1][c]  -P[r][c]
      // Query: +P[b+1][rc+1]  -P[b+1][l]  -P[t][rc+1]  +P[t][l]
      unique case ({mode_ff, step_ff[1:0]})
         {MODE_LOAD,  2'd0}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b010;
         {MODE_LOAD,  2'd1}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b100;
         {MODE_LOAD,  2'd2}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b001;
         {MODE_QUERY, 2'd0}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b110;
         {MODE_QUERY, 2'd1}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b101;
         {MODE_QUERY, 2'd2}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b011;
         {MODE_QUERY, 2'd3}: {sel_row_hi, sel_col_hi, sel_sub} = 3'b000;
         default:            {sel_row_hi, sel_col_hi, sel_sub} = 3'b000;
      endcase

      // Term arrives in the cycle after its read; negate through invert plus carry-in
      term   = rd_data ^ {SUM_W{sub_ff}};
      acc_in = acc_ff + term + {{(SUM_W-1){1'b0}}, sub_ff};

      tbl_ctl.rd_en   = issue;
      tbl_ctl.rd_row  = sel_row_hi ? row_hi_ff : row_lo_ff;
      tbl_ctl.rd_col  = sel_col_hi ? col_hi_ff : col_lo_ff;
      tbl_ctl.wr_en   = (state_ff == ST_READ) && (mode_ff == MODE_LOAD)
                     && (step_ff == term_count);
      tbl_ctl.wr_row  = row_hi_ff;
      tbl_ctl.wr_col  = col_hi_ff;
      tbl_ctl.wr_data = acc_in;

      rsp_load     = (state_ff == ST_DONE) && rsp_slot_free;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         row_count_ff <= CNT_W'(MAX_ROWS);
         col_count_ff <= CNT_W'(MAX_COLS);
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= mode_type'(req_ch.mode);
         err_ff  <= req_is_query && query_bad;
         if (req_is_query) begin
            row_lo_ff <= {1'b0, req_ch.top_row};
            row_hi_ff <= {1'b0, req_ch.bottom_row} + CNT_W'(1);
            col_lo_ff <= {1'b0, req_ch.left_col};
            col_hi_ff <= {1'b0, req_ch.right_col} + CNT_W'(1);
            acc_ff    <= '0;
         end else begin
            row_lo_ff <= {1'b0, cur_row};
            row_hi_ff <= next_row;
            col_lo_ff <= {1'b0, cur_col};
            col_hi_ff <= next_col;
            acc_ff    <= {{(SUM_W-ELEM_WIDTH){req_ch.element[ELEM_WIDTH-1]}}, req_ch.element};
         end
      end else if ((state_ff == ST_READ) && (step_ff != '0)) begin
         acc_ff <= acc_in;
      end
      if (issue) begin
         sub_ff <= sel_sub;
      end
      if (rsp_load) begin
         rsp_sum_ff <= err_ff ? '0 : acc_ff;
         rsp_err_ff <= err_ff;
      end
   end

   rs2d_table u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.range_sum   = rsp_sum_ff;
   assign rsp_ch.query_error = rsp_err_ff;

endmodule

// ===== sv/rs2d_checker.sv =====
// Port-level checks for the 2D range-sum unit, attached to the top level by bind.
// Depends on rs2d_pkg and range_sum_2d_prefix_table_unit.
module rs2d_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rs2d_pkg::SUM_W-1:0] rsp_sum,
   input logic                       rsp_error
);
   import rs2d_pkg::*;

   // A failed query carries a zero sum
   a_error_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_sum == '0)
      else $error("query_error beat with non-zero range_sum");

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum) && $stable(rsp_error))
      else $error("stalled response beat changed or dropped");

   // One item at a time: ready drops after every accepted request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item in progress");

   // A load never raises a response
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (mode_type'(req_mode) == MODE_LOAD) |=> !$rose(rsp_valid))
      else $error("response beat raised by a load");

endmodule

bind range_sum_2d_prefix_table_unit rs2d_checker u_rs2d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_mode  (req_ch.mode),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_sum   (rsp_ch.range_sum),
   .rsp_error (rsp_ch.query_error)
);
